>>> src/ssr_pkg.sv
// ----------------------------------------------------------------------------
// ssr_pkg
// shared constants and types of the stream substring replace unit
// ----------------------------------------------------------------------------
package ssr_pkg;

   // byte lanes of the pattern and replacement words
   localparam int WORD_BYTES    = 8;
   localparam int MAX_PATTERN   = 8;
   localparam int MAX_REPL      = 8;
   localparam int MAX_INPUT_LEN = 2046;

   // window holds at most one byte less than the longest pattern
   localparam int WIN_DEPTH = WORD_BYTES - 1;
   localparam int IDX_W     = $clog2(WORD_BYTES);
   localparam int TOT_W     = $clog2(WORD_BYTES + 1);
   localparam int LEN_W     = $clog2(MAX_INPUT_LEN + 2);

   // job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // configuration port
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;
   localparam int LENGTH_W   = 4;

   typedef enum logic [1:0] {
      REG_PATTERN_BYTES      = 2'd0,
      REG_PATTERN_LENGTH     = 2'd1,
      REG_REPLACEMENT_BYTES  = 2'd2,
      REG_REPLACEMENT_LENGTH = 2'd3
   } reg_index_type;

   // configuration as seen by the datapath, lengths already clamped
   typedef struct packed {
      logic [WORD_BYTES-1:0][7:0] pattern;
      logic [LENGTH_W-1:0]        plen;
      logic [WORD_BYTES-1:0][7:0] repl;
      logic [LENGTH_W-1:0]        rlen;
      logic                       clear;
   } ssr_cfg_type;

   // one queued job: a burst of 1 to 8 results
   typedef struct packed {
      logic [WORD_BYTES-1:0][7:0] data;
      logic [IDX_W-1:0]           last_idx;
      logic                       is_end;
      logic                       no_char;
      logic                       failed;
   } ssr_job_type;

   // queue status toward the front and back
   typedef struct packed {
      logic full;
      logic head_valid;
   } ssr_queue_status_type;

endpackage

>>> src/ssr_req_if.sv
// ----------------------------------------------------------------------------
// ssr_req_if
// input byte channel: valid/ready with one text byte and its final flag
// ----------------------------------------------------------------------------
interface ssr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       final_byte;

   modport source (output valid, output text_byte, output final_byte, input ready);
   modport sink (input valid, input text_byte, input final_byte, output ready);
   modport monitor (input valid, input text_byte, input final_byte, input ready);
endinterface

>>> src/ssr_rsp_if.sv
// ----------------------------------------------------------------------------
// ssr_rsp_if
// result channel: valid/ready with one rewritten byte and its flags
// ----------------------------------------------------------------------------
interface ssr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       end_of_string;
   logic       failed;

   modport source (output valid, output out_byte, output byte_valid,
                   output end_of_string, output failed, input ready);
   modport sink (input valid, input out_byte, input byte_valid,
                 input end_of_string, input failed, output ready);
   modport monitor (input valid, input out_byte, input byte_valid,
                    input end_of_string, input failed, input ready);
endinterface

>>> src/ssr_csr.sv
// ----------------------------------------------------------------------------
// ssr_csr
// apb register file: pattern and replacement words and their lengths
// ----------------------------------------------------------------------------
module ssr_csr import ssr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output ssr_cfg_type           cfg
);

   logic [CSR_DATA_W-1:0] pat_ff, pat_in;
   logic [CSR_DATA_W-1:0] rep_ff, rep_in;
   logic [LENGTH_W-1:0]   plen_ff, plen_in;
   logic [LENGTH_W-1:0]   rlen_ff, rlen_in;
   logic                  wr_strobe;
   reg_index_type         reg_sel;

   assign pready    = 1'b1;
   assign wr_strobe = psel && penable && pwrite && pready;
   assign reg_sel   = reg_index_type'(paddr[CSR_ADDR_W-1:3]);

   always_comb begin
      pat_in  = pat_ff;
      rep_in  = rep_ff;
      plen_in = plen_ff;
      rlen_in = rlen_ff;
      if (wr_strobe) begin
         case (reg_sel)
            REG_PATTERN_BYTES:      pat_in  = pwdata;
            REG_PATTERN_LENGTH:     plen_in = pwdata[LENGTH_W-1:0];
            REG_REPLACEMENT_BYTES:  rep_in  = pwdata;
            REG_REPLACEMENT_LENGTH: rlen_in = pwdata[LENGTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff  <= '0;
         rep_ff  <= '0;
         plen_ff <= '0;
         rlen_ff <= '0;
      end else begin
         pat_ff  <= pat_in;
         rep_ff  <= rep_in;
         plen_ff <= plen_in;
         rlen_ff <= rlen_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_PATTERN_BYTES:      prdata = pat_ff;
         REG_PATTERN_LENGTH:     prdata = {{(CSR_DATA_W-LENGTH_W){1'b0}}, plen_ff};
         REG_REPLACEMENT_BYTES:  prdata = rep_ff;
         REG_REPLACEMENT_LENGTH: prdata = {{(CSR_DATA_W-LENGTH_W){1'b0}}, rlen_ff};
         default:                prdata = '0;
      endcase
   end

   // oversized lengths count as the maximum
   always_comb begin
      cfg.pattern = pat_ff;
      cfg.repl    = rep_ff;
      cfg.plen    = (plen_ff > LENGTH_W'(MAX_PATTERN)) ? LENGTH_W'(MAX_PATTERN) : plen_ff;
      cfg.rlen    = (rlen_ff > LENGTH_W'(MAX_REPL)) ? LENGTH_W'(MAX_REPL) : rlen_ff;
      cfg.clear   = wr_strobe;
   end

endmodule

>>> src/ssr_front.sv
// ----------------------------------------------------------------------------
// ssr_front
// accepts text bytes, tracks the pending window and builds a job for each byte that releases results or ends a string
// ----------------------------------------------------------------------------
module ssr_front import ssr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  ssr_cfg_type          cfg,
   ssr_req_if.sink              req,
   input  ssr_queue_status_type q_status,
   output logic                 push,
   output ssr_job_type          job
);

   logic [WIN_DEPTH-1:0][7:0]  win_ff, win_in;
   logic [IDX_W-1:0]           cnt_ff, cnt_in;
   logic [LEN_W-1:0]           len_ff, len_in;

   logic                       accept;
   logic [IDX_W-1:0]           pm1;
   logic [IDX_W-1:0]           n;
   logic [WORD_BYTES-1:0][7:0] win_ext;
   logic [WORD_BYTES-1:0][7:0] cand;
   logic [WORD_BYTES-1:0][7:0] cand_shift;
   logic [TOT_W-1:0]           total;
   logic [WORD_BYTES-1:0]      pref;
   logic                       match;
   logic [TOT_W-1:0]           drop;
   logic [TOT_W-1:0]           count;
   logic [LEN_W-1:0]           len_inc;
   logic                       fail;
   logic                       empty_out;

   assign req.ready = !q_status.full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      pm1     = (cfg.plen == '0) ? '0 : IDX_W'(cfg.plen - LENGTH_W'(1));
      n       = (cnt_ff > pm1) ? pm1 : cnt_ff;
      win_ext = {8'h00, win_ff};
      total   = TOT_W'(n) + TOT_W'(1);

      // candidate: pending bytes followed by the new byte
      for (int i = 0; i < WORD_BYTES; i++) begin
         if (IDX_W'(i) < n) begin
            cand[i] = win_ext[i];
         end else if (IDX_W'(i) == n) begin
            cand[i] = req.text_byte;
         end else begin
            cand[i] = 8'h00;
         end
      end

      // pref[d]: candidate without its first d bytes is a pattern prefix
      for (int d = 0; d < WORD_BYTES; d++) begin
         pref[d] = 1'b1;
         for (int j = d; j < WORD_BYTES; j++) begin
            if (TOT_W'(j) < total && cand[j] != cfg.pattern[j-d]) begin
               pref[d] = 1'b0;
            end
         end
      end

      match = (TOT_W'(cfg.plen) == total) && pref[0];

      // fewest leading bytes to release
      drop = total;
      for (int d = WORD_BYTES - 1; d >= 0; d--) begin
         if (TOT_W'(d) < total && pref[d]) begin
            drop = TOT_W'(d);
         end
      end
      cand_shift = cand >> {drop, 3'b000};

      len_inc = (len_ff <= LEN_W'(MAX_INPUT_LEN)) ? len_ff + LEN_W'(1) : len_ff;
      fail    = (cfg.plen == '0) || (len_inc > LEN_W'(MAX_INPUT_LEN));

      if (match) begin
         count = TOT_W'(cfg.rlen);
      end else if (req.final_byte) begin
         count = total;
      end else begin
         count = drop;
      end
      empty_out = fail || (count == '0);

      job.data     = match ? cfg.repl : cand;
      job.last_idx = empty_out ? '0 : IDX_W'(count - TOT_W'(1));
      job.is_end   = req.final_byte;
      job.no_char  = empty_out;
      job.failed   = fail;

      push = accept && (fail ? req.final_byte : (req.final_byte || count != '0));

      win_in = win_ff;
      cnt_in = cnt_ff;
      len_in = len_ff;
      if (cfg.clear) begin
         cnt_in = '0;
         len_in = '0;
      end else if (accept) begin
         if (fail) begin
            cnt_in = '0;
            len_in = req.final_byte ? '0 : len_inc;
         end else if (req.final_byte) begin
            cnt_in = '0;
            len_in = '0;
         end else begin
            win_in = cand_shift[WIN_DEPTH-1:0];
            cnt_in = match ? '0 : IDX_W'(total - drop);
            len_in = len_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         len_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         len_ff <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

>>> src/ssr_queue.sv
// ----------------------------------------------------------------------------
// ssr_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module ssr_queue import ssr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ssr_job_type          push_job,
   input  logic                 pop,
   output ssr_job_type          head_job,
   output ssr_queue_status_type status
);

   ssr_job_type       mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_pop;

   assign status.full       = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.head_valid = (cnt_ff != '0);
   assign head_job          = mem_ff[rd_ff];
   assign do_pop            = pop && status.head_valid;

   always_comb begin
      wr_in  = push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in  = do_pop ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

endmodule

>>> src/ssr_back.sv
// ----------------------------------------------------------------------------
// ssr_back
// walks the head job one result per cycle into the output register while the output is not stalled
// ----------------------------------------------------------------------------
module ssr_back import ssr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  ssr_job_type          head_job,
   input  ssr_queue_status_type q_status,
   output logic                 pop,
   ssr_rsp_if.source            rsp
);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             bvalid_ff, bvalid_in;
   logic             eos_ff, eos_in;
   logic             fail_ff, fail_in;
   logic             load;
   logic             at_last;

   always_comb begin
      load    = q_status.head_valid && (!valid_ff || rsp.ready);
      at_last = (idx_ff == head_job.last_idx);
      pop     = load && at_last;

      idx_in    = idx_ff;
      valid_in  = valid_ff && !rsp.ready;
      byte_in   = byte_ff;
      bvalid_in = bvalid_ff;
      eos_in    = eos_ff;
      fail_in   = fail_ff;
      if (load) begin
         idx_in    = at_last ? '0 : idx_ff + IDX_W'(1);
         valid_in  = 1'b1;
         byte_in   = head_job.no_char ? 8'h00 : head_job.data[idx_ff];
         bvalid_in = !head_job.no_char;
         eos_in    = head_job.is_end && at_last;
         fail_in   = head_job.failed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      bvalid_ff <= bvalid_in;
      eos_ff    <= eos_in;
      fail_ff   <= fail_in;
   end

   assign rsp.valid         = valid_ff;
   assign rsp.out_byte      = byte_ff;
   assign rsp.byte_valid    = bvalid_ff;
   assign rsp.end_of_string = eos_ff;
   assign rsp.failed        = fail_ff;

endmodule

>>> src/stream_substring_replace_unit.sv
// ----------------------------------------------------------------------------
// stream_substring_replace_unit
// byte-serial find and replace of a configured pattern in a text stream
// ----------------------------------------------------------------------------
//
//   channel   | direction | handshake              | carries
//   ----------+-----------+------------------------+-------------------------------
//   req_if    | in        | valid / ready          | text_byte, final_byte
//   rsp_if    | out       | valid / ready          | out_byte, byte_valid,
//             |           |                        | end_of_string, failed
//   apb       | in        | psel, penable, pready  | 64-bit registers at 8 * index
//
// cycles: an input transfer is taken every cycle while the job queue has room;
//   an input byte yields k results (k from 0 to 8), which the back end issues
//   one per cycle while the output is not stalled
// path: each job is queued, then the back end registers its results for output
// reset: synchronous, clears window count, length counter, queue pointers and
//   the output valid; configuration registers reset to zero
// stalls: a four-job queue parts the two sides, so the input keeps flowing
//   while a result waits, and backs up only once four jobs are queued
//
module stream_substring_replace_unit import ssr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ssr_req_if.sink               req_if,
   ssr_rsp_if.source             rsp_if,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   ssr_cfg_type          cfg;
   ssr_queue_status_type q_status;
   ssr_job_type          push_job;
   ssr_job_type          head_job;
   logic                 push;
   logic                 pop;

   // register file; any write also restarts the current string
   ssr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // front: window compare and per-byte job build
   ssr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req      (req_if),
      .q_status (q_status),
      .push     (push),
      .job      (push_job)
   );

   // jobs waiting for the back end
   ssr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   // back: one result transfer per cycle from the head job while the output is not stalled
   ssr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_job (head_job),
      .q_status (q_status),
      .pop      (pop),
      .rsp      (rsp_if)
   );

endmodule

>>> src/ssr_checker.sv
// ----------------------------------------------------------------------------
// ssr_checker
// port-level checks of the result channel, bound to the top level
// ----------------------------------------------------------------------------
module ssr_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_end_of_string,
   input logic       rsp_failed
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_out_byte) && $stable(rsp_byte_valid)
         && $stable(rsp_end_of_string) && $stable(rsp_failed))
      else $error("stalled result changed");

   // a failed string ends in a bare end marker
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_failed |->
         !rsp_byte_valid && rsp_end_of_string && rsp_out_byte == 8'h00)
      else $error("failure flag outside end marker");

   // results without a character only close a string
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_end_of_string)
      else $error("empty result not at end of string");

   // nothing is offered right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind stream_substring_replace_unit ssr_checker u_ssr_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_out_byte      (rsp_if.out_byte),
   .rsp_byte_valid    (rsp_if.byte_valid),
   .rsp_end_of_string (rsp_if.end_of_string),
   .rsp_failed        (rsp_if.failed)
);

>>> bench/tb_stream_substring_replace_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stream_substring_replace_unit
// self-checking bench for the byte-serial find and replace unit
// ----------------------------------------------------------------------------
// A short directed table comes first. It covers an empty pattern, deletion,
// oversized lengths, zero bytes and a full window flush. Random phases follow,
// each with new register values and its own idling mode for the two channels.
// Each result transfer is checked against a bench-side rewrite or a typed row.
// ----------------------------------------------------------------------------
module tb_stream_substring_replace_unit;
   import ssr_pkg::*;

   localparam real CLK_PERIOD    = 12.0;
   localparam int  RESET_CYCLES  = 6;
   localparam int  SETTLE_CYCLES = 8;       // idle margin after the last owed result
   localparam int  CYCLE_LIMIT   = 300000;
   localparam int  MAX_REPORTS   = 40;
   localparam int  RANDOM_PHASES = 8;

   // one result transfer as the consumer sees it
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       end_of_string;
      logic       failed;
   } text_result_type;

   typedef enum logic [1:0] {
      IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH
   } idle_mode_type;
   typedef enum logic [1:0] {CHK_PREDICTED, CHK_NONE, CHK_TYPED} check_mode_type;
   typedef enum logic {ROW_TEXT, ROW_CSR} row_kind_type;

   // one line of the directed table: a register write or a text byte
   typedef struct packed {
      row_kind_type    kind;
      reg_index_type   csr;
      logic [63:0]     value;
      logic [7:0]      text;
      logic            fin;
      check_mode_type  check;
      text_result_type want;
   } stim_row_type;

   localparam text_result_type END_FAILED = '{8'h00, 1'b0, 1'b1, 1'b1};
   localparam text_result_type END_EMPTY  = '{8'h00, 1'b0, 1'b1, 1'b0};

   logic clock = 1'b0;
   logic reset;

   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   ssr_req_if req_bus ();
   ssr_rsp_if rsp_bus ();

   stream_substring_replace_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_bus),
      .rsp_if  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #(CLK_PERIOD / 2.0) clock = ~clock;

   // ------------------------------------------------------------------------
   // bench copy of the unit: registers, held-back bytes, string length
   // ------------------------------------------------------------------------
   logic [63:0] pat_word;
   logic [3:0]  pat_len;
   logic [63:0] repl_word;
   logic [3:0]  repl_len;
   logic [7:0]  held [7];
   int          held_count;
   int          seen_len;

   // results still owed by the unit, oldest first
   text_result_type due_chars [$];

   // idling knobs, read by the sender and the receiver
   int send_gap_pct;
   int stall_pct;
   int hold_request;

   // run statistics
   int text_transfers;
   int result_transfers;
   int strings_closed;
   int failed_strings;
   int csr_writes;
   int replacements_made;
   int mismatches;
   int cycle_count;

   function automatic logic [7:0] lane(input logic [63:0] w, input int i);
      return w[i*8 +: 8];
   endfunction

   // true when the first n bytes of win agree with the pattern
   function automatic bit is_pattern_head(input logic [7:0] win [8], input int n);
      int i;
      for (i = 0; i < n; i++) begin
         if (win[i] != lane(pat_word, i)) return 1'b0;
      end
      return 1'b1;
   endfunction

   // rewrite one text byte and return the results it releases
   function automatic void rewrite_byte(input logic [7:0] c, input logic fin,
                                        output text_result_type res [$]);
      logic [7:0]      win [8];
      int              plen;
      int              rlen;
      int              n;
      int              i;
      text_result_type tail;
      res  = {};
      plen = (pat_len > 8) ? 8 : pat_len;
      rlen = (repl_len > 8) ? 8 : repl_len;
      // length counter saturates one past the limit
      if (seen_len <= MAX_INPUT_LEN) seen_len++;
      // empty pattern or overlong string: nothing passes, the end is flagged
      if (plen == 0 || seen_len > MAX_INPUT_LEN) begin
         held_count = 0;
         if (fin) begin
            res.push_back(END_FAILED);
            seen_len = 0;
         end
         return;
      end
      n = (held_count > plen - 1) ? plen - 1 : held_count;
      for (i = 0; i < n; i++) win[i] = held[i];
      win[n] = c;
      n++;
      if (n == plen && is_pattern_head(win, n)) begin
         // whole pattern seen: send the replacement, scanning restarts after it
         for (i = 0; i < rlen; i++) res.push_back('{lane(repl_word, i), 1'b1, 1'b0, 1'b0});
         replacements_made++;
         n = 0;
      end else begin
         // release leading bytes until what is left could still start a match
         while (n > 0 && !is_pattern_head(win, n)) begin
            res.push_back('{win[0], 1'b1, 1'b0, 1'b0});
            for (i = 1; i < n; i++) win[i-1] = win[i];
            n--;
         end
      end
      if (fin) begin
         for (i = 0; i < n; i++) res.push_back('{win[i], 1'b1, 1'b0, 1'b0});
         if (res.size() == 0) res.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
         tail = res.pop_back();
         tail.end_of_string = 1'b1;
         res.push_back(tail);
         held_count = 0;
         seen_len   = 0;
      end else begin
         for (i = 0; i < n; i++) held[i] = win[i];
         held_count = n;
      end
   endfunction

   function automatic stim_row_type text_row(input logic [7:0] b, input logic fin,
                                             input check_mode_type chk = CHK_PREDICTED,
                                             input text_result_type want = '0);
      stim_row_type r;
      r       = '0;
      r.kind  = ROW_TEXT;
      r.text  = b;
      r.fin   = fin;
      r.check = chk;
      r.want  = want;
      return r;
   endfunction

   function automatic stim_row_type csr_row(input reg_index_type idx,
                                            input logic [63:0] value);
      stim_row_type r;
      r       = '0;
      r.kind  = ROW_CSR;
      r.csr   = idx;
      r.value = value;
      return r;
   endfunction

   // half the time a byte of the pattern, so partial matches keep happening
   function automatic logic [7:0] noise_byte(input int plen_now);
      if (plen_now > 0 && $urandom_range(1) == 1)
         return lane(pat_word, $urandom_range(plen_now - 1));
      return 8'($urandom_range(1, 255));
   endfunction

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_gap_pct = 0;
            stall_pct    = 0;
         end
         IDLE_SENDER: begin
            send_gap_pct = 62;
            stall_pct    = 0;
         end
         IDLE_RECEIVER: begin
            send_gap_pct = 0;
            stall_pct    = 62;
         end
         default: begin
            send_gap_pct = 20;
            stall_pct    = 20;
         end
      endcase
   endtask

   // wait until every owed result has arrived, then let the pipe run dry
   task automatic settle();
      while (due_chars.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // apb write, only ever issued with the unit idle
   task automatic write_csr(input reg_index_type idx, input logic [63:0] value);
      req_bus.valid <= 1'b0;
      settle();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         REG_PATTERN_BYTES:      pat_word  = value;
         REG_PATTERN_LENGTH:     pat_len   = value[3:0];
         REG_REPLACEMENT_BYTES:  repl_word = value;
         REG_REPLACEMENT_LENGTH: repl_len  = value[3:0];
         default: ;
      endcase
      // any write starts a new string
      held_count = 0;
      seen_len   = 0;
      csr_writes++;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // offer one text byte, after a random gap; on transfer, book its results
   task automatic send_text(input logic [7:0] b, input logic fin,
                            input check_mode_type chk = CHK_PREDICTED,
                            input text_result_type want = '0);
      text_result_type fresh [$];
      while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.text_byte  <= b;
      req_bus.final_byte <= fin;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      // the bench state always advances; typed rows replace what is owed
      rewrite_byte(b, fin, fresh);
      case (chk)
         CHK_PREDICTED: foreach (fresh[k]) due_chars.push_back(fresh[k]);
         CHK_TYPED:     due_chars.push_back(want);
         default: ;
      endcase
      text_transfers++;
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // result checker: every result transfer against the oldest owed result
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      text_result_type got;
      text_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.out_byte, rsp_bus.byte_valid, rsp_bus.end_of_string, rsp_bus.failed};
         result_transfers++;
         if (got.end_of_string) strings_closed++;
         if (got.end_of_string && got.failed) failed_strings++;
         if (due_chars.size() == 0) begin
            if (mismatches < MAX_REPORTS)
               $display("%0t: unexpected result byte %h valid %b end %b failed %b",
                        $time, got.out_byte, got.byte_valid, got.end_of_string, got.failed);
            mismatches++;
         end else begin
            want = due_chars.pop_front();
            if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                got.end_of_string !== want.end_of_string || got.failed !== want.failed) begin
               if (mismatches < MAX_REPORTS)
                  $display({"%0t: mismatch, expected byte %h valid %b end %b failed %b,",
                            " got byte %h valid %b end %b failed %b"},
                           $time, want.out_byte, want.byte_valid, want.end_of_string,
                           want.failed, got.out_byte, got.byte_valid, got.end_of_string,
                           got.failed);
               mismatches++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // receiver: random stalls, plus long hold-offs on request
   // ------------------------------------------------------------------------
   initial begin
      int hold_left;
      rsp_bus.ready = 1'b0;
      hold_left     = 0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: no progress within %0d cycles", $time, CYCLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   stim_row_type directed_rows [$];

   initial begin
      int          phase;
      int          quota;
      int          sent;
      int          target;
      int          pick;
      int          cut;
      int          plen_now;
      int          new_plen;
      int          new_rlen;
      bit          paused;
      logic [63:0] word;
      logic [7:0]  text_q [$];

      // every input known from time zero
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.text_byte  = 8'h00;
      req_bus.final_byte = 1'b0;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      send_gap_pct       = 0;
      stall_pct          = 0;
      hold_request       = 0;
      pat_word           = '0;
      pat_len            = '0;
      repl_word          = '0;
      repl_len           = '0;
      held_count         = 0;
      seen_len           = 0;
      text_transfers     = 0;
      result_transfers   = 0;
      strings_closed     = 0;
      failed_strings     = 0;
      csr_writes         = 0;
      replacements_made  = 0;
      mismatches         = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table; typed results only where obvious
      directed_rows = '{
         // out of reset the pattern is empty: nothing passes, the end fails
         text_row(8'h61, 1'b0, CHK_NONE),
         text_row(8'h62, 1'b1, CHK_TYPED, END_FAILED),
         // "ab" -> "XYZ", unused upper lanes all ones
         csr_row(REG_PATTERN_BYTES,      64'hFFFF_FFFF_FFFF_6261),
         csr_row(REG_PATTERN_LENGTH,     64'd2),
         csr_row(REG_REPLACEMENT_BYTES,  64'hFFFF_FFFF_FF5A_5958),
         csr_row(REG_REPLACEMENT_LENGTH, 64'd3),
         text_row(8'h78, 1'b0),
         text_row(8'h61, 1'b0),
         text_row(8'h62, 1'b0),
         text_row(8'h61, 1'b0),
         text_row(8'h61, 1'b0),
         text_row(8'h62, 1'b1),
         // single held byte flushed at the end
         text_row(8'h61, 1'b1),
         // empty replacement deletes; an empty string end is a bare marker
         csr_row(REG_REPLACEMENT_LENGTH, 64'd0),
         text_row(8'h61, 1'b0),
         text_row(8'h62, 1'b1, CHK_TYPED, END_EMPTY),
         // zero bytes in pattern, text and replacement; oversized replacement
         csr_row(REG_PATTERN_BYTES,      64'h0000_0000_0000_4100),
         csr_row(REG_REPLACEMENT_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF),
         csr_row(REG_REPLACEMENT_BYTES,  64'h0102_0304_0500_07FF),
         text_row(8'h00, 1'b0),
         text_row(8'h41, 1'b0),
         text_row(8'hFF, 1'b1),
         // oversized pattern length: full eight-byte pattern, window filled
         // with seven bytes and flushed by a final mismatch
         csr_row(REG_PATTERN_BYTES,      64'h4847_4645_4443_4241),
         csr_row(REG_PATTERN_LENGTH,     64'h0000_0000_0000_000F),
         csr_row(REG_REPLACEMENT_LENGTH, 64'd1),
         text_row(8'h41, 1'b0),
         text_row(8'h42, 1'b0),
         text_row(8'h43, 1'b0),
         text_row(8'h44, 1'b0),
         text_row(8'h45, 1'b0),
         text_row(8'h46, 1'b0),
         text_row(8'h47, 1'b0),
         text_row(8'h58, 1'b1)
      };

      set_idling(IDLE_NONE);
      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CSR) begin
            write_csr(directed_rows[r].csr, directed_rows[r].value);
         end else begin
            send_text(directed_rows[r].text, directed_rows[r].fin,
                      directed_rows[r].check, directed_rows[r].want);
         end
      end

      // random phases: fresh registers, then strings built around the pattern
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               new_plen = 8;
               new_rlen = 8;
            end
            1: begin
               new_plen = 1;
               new_rlen = 0;
            end
            2: begin
               new_plen = 15;
               new_rlen = 15;
            end
            3: begin
               new_plen = 0;
               new_rlen = $urandom_range(0, 8);
            end
            default: begin
               new_plen = $urandom_range(1, 8);
               new_rlen = $urandom_range(0, 8);
            end
         endcase
         // pattern mostly from a three-letter alphabet to force overlaps
         for (int i = 0; i < 8; i++)
            word[i*8 +: 8] = ($urandom_range(3) != 0) ? 8'(8'h61 + $urandom_range(2))
                                                      : 8'($urandom_range(1, 255));
         write_csr(REG_PATTERN_BYTES, word);
         // length registers carry junk above the low nibble
         word      = {$urandom, $urandom};
         word[3:0] = 4'(new_plen);
         write_csr(REG_PATTERN_LENGTH, word);
         write_csr(REG_REPLACEMENT_BYTES, {$urandom, $urandom});
         word      = {$urandom, $urandom};
         word[3:0] = 4'(new_rlen);
         write_csr(REG_REPLACEMENT_LENGTH, word);

         set_idling(idle_mode_type'(phase % 4));
         // long receiver hold-off while the sender keeps offering bytes
         if (phase == 4) hold_request = 120;

         plen_now = (pat_len > 8) ? 8 : pat_len;
         quota    = (phase == 3) ? 12 : 24;
         sent     = 0;
         paused   = 1'b0;
         while (sent < quota) begin
            text_q = {};
            target = ($urandom_range(19) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
            while (text_q.size() < target) begin
               pick = $urandom_range(99);
               if (pick < 45 && plen_now > 0) begin
                  // whole pattern
                  for (int i = 0; i < plen_now; i++) text_q.push_back(lane(pat_word, i));
               end else if (pick < 65 && plen_now > 1) begin
                  // broken-off prefix
                  cut = $urandom_range(1, plen_now - 1);
                  for (int i = 0; i < cut; i++) text_q.push_back(lane(pat_word, i));
                  text_q.push_back(noise_byte(plen_now));
               end else begin
                  text_q.push_back(noise_byte(plen_now));
               end
            end
            foreach (text_q[j]) send_text(text_q[j], j == text_q.size() - 1);
            sent += text_q.size();
            // sender stands still until the unit has delivered everything
            if (phase == 1 && !paused && sent >= quota / 2) begin
               paused        = 1'b1;
               req_bus.valid <= 1'b0;
               while (due_chars.size() != 0) @(negedge clock);
            end
         end
         // leave a pattern prefix held in the window; the next write drops it
         if (phase % 2 == 0 && plen_now > 1) begin
            cut = $urandom_range(1, plen_now - 1);
            for (int i = 0; i < cut; i++) send_text(lane(pat_word, i), 1'b0);
         end
      end

      req_bus.valid <= 1'b0;
      settle();

      $display("run covered %0d text transfers, %0d result transfers, %0d strings",
               text_transfers, result_transfers, strings_closed);
      $display("%0d strings failed, %0d register writes, %0d replacements, mixed idling",
               failed_strings, csr_writes, replacements_made);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d result checks failed", mismatches);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
